// ----- sv/acle_pkg.sv -----
// Package for the access control list engine: codes, states and defaults.
`default_nettype none

package acle_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int PERM_WIDTH_DEFAULT = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    TAG_USER  = 2'd0,
    TAG_GROUP = 2'd1,
    TAG_OTHER = 2'd2,
    TAG_MASK  = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DENIED    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_SHIFT,
    S_POST
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } eval_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/acle_eval.sv -----
// Access check evaluator: collects the winning entries of a scan and decides.
`default_nettype none

module acle_eval #(
  parameter int PERM_WIDTH = acle_pkg::PERM_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire acle_pkg::eval_ctrl_t   ctrl,
  input  wire logic [1:0]             ent_tag,
  input  wire logic [31:0]            ent_id,
  input  wire logic [PERM_WIDTH-1:0]  ent_perm,
  input  wire logic [31:0]            uid,
  input  wire logic [31:0]            gid,
  input  wire logic [7:0]             req,
  output logic                        grant
);

  localparam int GW = (PERM_WIDTH > 8) ? PERM_WIDTH : 8;

  logic has_u, has_g, has_o, has_m;
  logic [PERM_WIDTH-1:0] pu, pg, po, pm;
  logic [PERM_WIDTH-1:0] granted;
  logic [GW-1:0] granted_w, req_w;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      has_u <= 1'b0;
      has_g <= 1'b0;
      has_o <= 1'b0;
      has_m <= 1'b0;
    end else if (ctrl.step) begin
      // An entry counts for the first class it fits; a later match replaces an earlier one.
      if (ent_tag == acle_pkg::TAG_USER && ent_id == uid) begin
        has_u <= 1'b1;
        pu    <= ent_perm;
      end else if (ent_tag == acle_pkg::TAG_GROUP && ent_id == gid) begin
        has_g <= 1'b1;
        pg    <= ent_perm;
      end else if (ent_tag == acle_pkg::TAG_OTHER) begin
        has_o <= 1'b1;
        po    <= ent_perm;
      end else if (ent_tag == acle_pkg::TAG_MASK) begin
        has_m <= 1'b1;
        pm    <= ent_perm;
      end
    end
  end

  always_comb begin
    if (has_u) begin
      granted = has_m ? (pu & pm) : pu;
    end else if (has_g) begin
      granted = has_m ? (pg & pm) : pg;
    end else begin
      granted = po;
    end
  end

  assign granted_w = GW'(granted);
  assign req_w     = GW'(req);
  assign grant     = (has_u || has_g || has_o) && ((granted_w & req_w) == req_w);

endmodule

`default_nettype wire

// ----- sv/access_control_list_engine_unit.sv -----
// Top level of the access control list engine: entry table, sequencer and output register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode .. request_mask | into block
//  out     | out_valid, out_stall, status, entry_count  | out of block
//
// Add, an unknown opcode and a root check go from acceptance straight to S_POST.
// Check and remove first walk the table (S_SCAN, or S_FIND then S_SHIFT), reading
// one table entry per cycle through the single read port of the entry memory.
// One item is in work at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which may still hold the previous result.
// Reset clears the entry count; entries at or beyond the count are never read.
`default_nettype none

module access_control_list_engine_unit #(
  parameter int DEPTH      = acle_pkg::DEPTH_DEFAULT,
  parameter int PERM_WIDTH = acle_pkg::PERM_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [1:0]  entry_tag,
  input  wire logic [31:0] entry_id,
  input  wire logic [7:0]  entry_perm,
  input  wire logic [31:0] subject_uid,
  input  wire logic [31:0] subject_gid,
  input  wire logic [7:0]  request_mask,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [4:0]       entry_count
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW  = 2 + 32 + PERM_WIDTH;
  localparam int CXW = (CW > 5) ? CW : 5;

  acle_pkg::state_t  state, state_next;
  acle_pkg::status_t res_status, res_status_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] ridx;
  logic [CW-1:0] shift_addr;
  logic [CXW-1:0] count_x;
  logic          rvalid;

  logic [1:0]  q_tag;
  logic [31:0] q_id, q_uid, q_gid;
  logic [7:0]  q_req;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] mem_q;
  logic [EW-1:0] mem_wd;
  logic [AW-1:0] mem_wa;
  logic          mem_we;
  logic          rd_en;

  logic [1:0]            rd_tag;
  logic [31:0]           rd_id;
  logic [PERM_WIDTH-1:0] rd_perm;

  acle_pkg::eval_ctrl_t ectl;
  logic grant;
  logic acc, load, out_free, scan_more, match;

  assign rd_tag  = mem_q[EW-1 -: 2];
  assign rd_id   = mem_q[PERM_WIDTH +: 32];
  assign rd_perm = mem_q[PERM_WIDTH-1:0];

  assign in_stall   = (state != acle_pkg::S_IDLE);
  assign acc        = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign scan_more  = (idx < count);
  assign match      = rvalid && (rd_tag == q_tag) && (rd_id == q_id);
  assign shift_addr = ridx - CW'(1);
  assign count_x    = CXW'(count);

  acle_eval #(
    .PERM_WIDTH (PERM_WIDTH)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ectl),
    .ent_tag  (rd_tag),
    .ent_id   (rd_id),
    .ent_perm (rd_perm),
    .uid      (q_uid),
    .gid      (q_gid),
    .req      (q_req),
    .grant    (grant)
  );

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    count_next      = count;
    idx_next        = idx;
    mem_we          = 1'b0;
    mem_wa          = count[AW-1:0];
    mem_wd          = {entry_tag, entry_id, PERM_WIDTH'(entry_perm)};
    rd_en           = 1'b0;
    ectl            = '0;
    load            = 1'b0;
    unique case (state)
      acle_pkg::S_IDLE: begin
        if (acc) begin
          idx_next   = '0;
          ectl.clear = 1'b1;
          unique case (opcode)
            acle_pkg::OP_ADD: begin
              if (count == CW'(DEPTH)) begin
                res_status_next = acle_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                count_next      = count + CW'(1);
                res_status_next = acle_pkg::ST_OK;
              end
              state_next = acle_pkg::S_POST;
            end
            acle_pkg::OP_REMOVE: begin
              state_next = acle_pkg::S_FIND;
            end
            acle_pkg::OP_CHECK: begin
              if (subject_uid == 32'd0) begin
                res_status_next = acle_pkg::ST_OK;
                state_next      = acle_pkg::S_POST;
              end else begin
                state_next = acle_pkg::S_SCAN;
              end
            end
            default: begin
              res_status_next = acle_pkg::ST_DENIED;
              state_next      = acle_pkg::S_POST;
            end
          endcase
        end
      end
      acle_pkg::S_SCAN: begin
        rd_en     = scan_more;
        ectl.step = rvalid;
        if (scan_more) begin
          idx_next = idx + CW'(1);
        end
        if (!scan_more && !rvalid) begin
          res_status_next = grant ? acle_pkg::ST_OK : acle_pkg::ST_DENIED;
          state_next      = acle_pkg::S_POST;
        end
      end
      acle_pkg::S_FIND: begin
        rd_en = scan_more;
        if (scan_more) begin
          idx_next = idx + CW'(1);
        end
        // The read already issued this cycle is the entry that moves into the hole.
        if (match) begin
          state_next = acle_pkg::S_SHIFT;
        end else if (!scan_more && !rvalid) begin
          res_status_next = acle_pkg::ST_NOT_FOUND;
          state_next      = acle_pkg::S_POST;
        end
      end
      acle_pkg::S_SHIFT: begin
        rd_en = scan_more;
        if (scan_more) begin
          idx_next = idx + CW'(1);
        end
        if (rvalid) begin
          mem_we = 1'b1;
          mem_wa = shift_addr[AW-1:0];
          mem_wd = mem_q;
        end
        if (!scan_more && !rvalid) begin
          count_next      = count - CW'(1);
          res_status_next = acle_pkg::ST_OK;
          state_next      = acle_pkg::S_POST;
        end
      end
      acle_pkg::S_POST: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = acle_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = acle_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= acle_pkg::S_IDLE;
      count  <= '0;
      idx    <= '0;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      rvalid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    ridx       <= idx;
    if (acc) begin
      q_tag <= entry_tag;
      q_id  <= entry_id;
      q_uid <= subject_uid;
      q_gid <= subject_gid;
      q_req <= request_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= res_status;
      entry_count <= count_x[4:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && opcode == acle_pkg::OP_ADD && count != CW'(DEPTH)) |=>
      (count == $past(count) + CW'(1)))
    else $error("add did not grow the table");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == acle_pkg::S_SHIFT && state_next == acle_pkg::S_POST) |=>
      (count == $past(count) - CW'(1)))
    else $error("remove did not shrink the table");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == acle_pkg::S_SHIFT && mem_we) |-> (ridx != '0 && ridx < count))
    else $error("shift writes outside the valid entries");
`endif

endmodule

`default_nettype wire
